>>> hw/rtl/mac_share_modular_alu_macros.svh
// Assertion macros shared by the modular share ALU.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MAC_SHARE_MODULAR_ALU_MACROS_SVH
`define MAC_SHARE_MODULAR_ALU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSMA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mac_share_modular_alu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mac_share_modular_alu: next-cycle check failed");

`endif

>>> hw/rtl/msma_pkg.sv
package msma_pkg;

    localparam int ELEM_W     = 23;
    localparam int CONST_W    = 24;
    localparam int PARTY_W    = 8;
    localparam int NUM_PARTS  = 3;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int RES_W      = ELEM_W + 2;
    localparam int PRE_SHIFT  = ELEM_W - 1;
    localparam int HI_W       = SUM_W - PRE_SHIFT;
    localparam int POST_SHIFT = SUM_W - PRE_SHIFT;
    localparam int MU_W       = 26;
    localparam int BAR_PROD_W = HI_W + MU_W;
    localparam int QUOT_W     = BAR_PROD_W - POST_SHIFT;
    localparam int QQ_W       = QUOT_W + ELEM_W;

    localparam int PART_VALUE  = 0;
    localparam int PART_MAC    = 1;
    localparam int PART_OFFSET = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam longint unsigned MODULUS_L = 64'd8380417;

    localparam logic [ELEM_W-1:0] MODULUS     = ELEM_W'(MODULUS_L);
    localparam logic [ELEM_W-1:0] ONE         = ELEM_W'(1);
    localparam logic [ELEM_W-1:0] MINUS_ONE   = ELEM_W'(MODULUS_L - 64'd1);
    localparam logic [MU_W-1:0]   BARRETT_MU  = MU_W'((64'd1 << SUM_W) / MODULUS_L);
    localparam logic [PARTY_W-1:0] ACTIVE_PARTY = PARTY_W'(1);

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_ADD_CONST = 3'd2,
        OP_MUL_CONST = 3'd3,
        OP_BEAVER    = 3'd4
    } op_t;

    typedef enum logic [0:0] {
        REG_PARTY_INDEX = 1'b0
    } reg_idx_t;

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef elem_t [NUM_PARTS-1:0] share_t;
    typedef sum_t  [NUM_PARTS-1:0] share_sum_t;

    // One part of a share is computed as a1*b1 + a2*b2 + a3*b3 + addend mod Q.
    typedef struct packed {
        elem_t a1;
        elem_t b1;
        elem_t a2;
        elem_t b2;
        elem_t a3;
        elem_t b3;
        elem_t addend;
    } terms_t;

    typedef terms_t [NUM_PARTS-1:0] share_terms_t;

    function automatic elem_t reduce_once(input elem_t x);
        elem_t r;
        r = (x >= MODULUS) ? elem_t'(x - MODULUS) : x;
        return r;
    endfunction

endpackage

>>> hw/rtl/msma_prep.sv
module msma_prep
    import msma_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid_in,
    input  logic [2:0]                req_type,
    input  share_t                    first,
    input  share_t                    second,
    input  share_t                    third,
    input  logic signed [CONST_W-1:0] const_one,
    input  elem_t                     const_two,
    input  logic [PARTY_W-1:0]        party_index,
    output logic                      valid_out,
    output share_terms_t              terms
);

    share_t                    f_red;
    share_t                    s_red;
    share_t                    t_red;
    logic signed [CONST_W:0]   c1_ext;
    logic signed [CONST_W:0]   c1_minus_q;
    logic signed [CONST_W:0]   c1_plus_q;
    logic signed [CONST_W:0]   c1_plus_2q;
    logic signed [CONST_W:0]   q_ext;
    elem_t                     c1_red;
    elem_t                     c1_neg;
    elem_t                     c2_red;
    elem_t                     c1_active;
    logic                      party_active;
    share_terms_t              terms_next;
    logic                      valid_reg;
    share_terms_t              terms_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            f_red[p] = reduce_once(first[p]);
            s_red[p] = reduce_once(second[p]);
            t_red[p] = reduce_once(third[p]);
        end

        q_ext      = signed'({2'b00, MODULUS});
        c1_ext     = {const_one[CONST_W-1], const_one};
        c1_minus_q = c1_ext - q_ext;
        c1_plus_q  = c1_ext + q_ext;
        c1_plus_2q = c1_plus_q + q_ext;

        if (!const_one[CONST_W-1])
        begin
            c1_red = c1_minus_q[CONST_W] ? c1_ext[ELEM_W-1:0] : c1_minus_q[ELEM_W-1:0];
        end
        else
        begin
            c1_red = c1_plus_q[CONST_W] ? c1_plus_2q[ELEM_W-1:0] : c1_plus_q[ELEM_W-1:0];
        end

        c1_neg       = MODULUS - c1_red;
        c2_red       = reduce_once(const_two);
        party_active = (party_index == ACTIVE_PARTY);
        c1_active    = party_active ? c1_red : '0;

        terms_next = '0;
        case (op_t'(req_type))
            OP_ADD:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                begin
                    terms_next[p].a1 = f_red[p];
                    terms_next[p].b1 = ONE;
                    terms_next[p].a2 = s_red[p];
                    terms_next[p].b2 = ONE;
                end
            end
            OP_SUB:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                begin
                    terms_next[p].a1 = f_red[p];
                    terms_next[p].b1 = ONE;
                    terms_next[p].a2 = s_red[p];
                    terms_next[p].b2 = MINUS_ONE;
                end
            end
            OP_ADD_CONST:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                begin
                    terms_next[p].a1 = f_red[p];
                    terms_next[p].b1 = ONE;
                end
                terms_next[PART_VALUE].addend  = c1_active;
                terms_next[PART_OFFSET].addend = c1_neg;
            end
            OP_MUL_CONST:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                begin
                    terms_next[p].a1 = f_red[p];
                    terms_next[p].b1 = c1_red;
                end
            end
            OP_BEAVER:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                begin
                    terms_next[p].a1     = f_red[p];
                    terms_next[p].b1     = c2_red;
                    terms_next[p].a2     = s_red[p];
                    terms_next[p].b2     = c1_red;
                    terms_next[p].b3     = c2_red;
                    terms_next[p].addend = t_red[p];
                end
                // The public product eps*delta goes into the value on party 1
                // and is taken from the offset on every party.
                terms_next[PART_VALUE].a3  = c1_active;
                terms_next[PART_OFFSET].a3 = c1_neg;
            end
            default:
            begin
                terms_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    assign valid_out = valid_reg;
    assign terms     = terms_reg;

endmodule

>>> hw/rtl/msma_mac.sv
module msma_mac
    import msma_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         valid_in,
    input  share_terms_t terms,
    output logic         valid_out,
    output share_sum_t   sums
);

    logic [PROD_W-1:0] prod1_next [NUM_PARTS];
    logic [PROD_W-1:0] prod2_next [NUM_PARTS];
    logic [PROD_W-1:0] prod3_next [NUM_PARTS];
    logic [PROD_W-1:0] prod1_reg  [NUM_PARTS];
    logic [PROD_W-1:0] prod2_reg  [NUM_PARTS];
    logic [PROD_W-1:0] prod3_reg  [NUM_PARTS];
    elem_t             addend_reg [NUM_PARTS];
    share_sum_t        sums_next;
    share_sum_t        sums_reg;
    logic              prod_valid_reg;
    logic              sum_valid_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            prod1_next[p] = PROD_W'(terms[p].a1) * PROD_W'(terms[p].b1);
            prod2_next[p] = PROD_W'(terms[p].a2) * PROD_W'(terms[p].b2);
            prod3_next[p] = PROD_W'(terms[p].a3) * PROD_W'(terms[p].b3);
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            sums_next[p] = SUM_W'(prod1_reg[p]) + SUM_W'(prod2_reg[p])
                         + SUM_W'(prod3_reg[p]) + SUM_W'(addend_reg[p]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= valid_in;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < NUM_PARTS; p++)
            begin
                prod1_reg[p]  <= prod1_next[p];
                prod2_reg[p]  <= prod2_next[p];
                prod3_reg[p]  <= prod3_next[p];
                addend_reg[p] <= terms[p].addend;
            end
            sums_reg <= sums_next;
        end
    end

    assign valid_out = sum_valid_reg;
    assign sums      = sums_reg;

endmodule

>>> hw/rtl/msma_red.sv
module msma_red
    import msma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       valid_in,
    input  share_sum_t sums,
    output logic       valid_out,
    output share_t     result
);

    localparam logic [RES_W-1:0] Q_RES     = RES_W'(MODULUS);
    localparam logic [RES_W-1:0] TWO_Q_RES = RES_W'(2 * MODULUS_L);

    logic [BAR_PROD_W-1:0] bar_prod   [NUM_PARTS];
    logic [QUOT_W-1:0]     quot_next  [NUM_PARTS];
    logic [QUOT_W-1:0]     quot_reg   [NUM_PARTS];
    logic [RES_W-1:0]      low_a_reg  [NUM_PARTS];
    logic [QQ_W-1:0]       qq_full    [NUM_PARTS];
    logic [RES_W-1:0]      qq_reg     [NUM_PARTS];
    logic [RES_W-1:0]      low_b_reg  [NUM_PARTS];
    logic [RES_W-1:0]      rem_raw    [NUM_PARTS];
    logic [RES_W-1:0]      rem_mid    [NUM_PARTS];
    logic [RES_W-1:0]      rem_fin    [NUM_PARTS];
    share_t                result_next;
    share_t                result_reg;
    logic                  quot_valid_reg;
    logic                  qq_valid_reg;
    logic                  result_valid_reg;

    // Barrett estimate: the quotient is at most two below the true one,
    // so the remainder stays under 3Q and fits in RES_W bits.
    always_comb
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            bar_prod[p]  = BAR_PROD_W'(sums[p][SUM_W-1:PRE_SHIFT]) * BAR_PROD_W'(BARRETT_MU);
            quot_next[p] = bar_prod[p][BAR_PROD_W-1:POST_SHIFT];
            qq_full[p]   = QQ_W'(quot_reg[p]) * QQ_W'(MODULUS);
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            rem_raw[p]     = low_b_reg[p] - qq_reg[p];
            rem_mid[p]     = (rem_raw[p] >= TWO_Q_RES) ? rem_raw[p] - TWO_Q_RES : rem_raw[p];
            rem_fin[p]     = (rem_mid[p] >= Q_RES) ? rem_mid[p] - Q_RES : rem_mid[p];
            result_next[p] = rem_fin[p][ELEM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_valid_reg   <= 1'b0;
            qq_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            quot_valid_reg   <= valid_in;
            qq_valid_reg     <= quot_valid_reg;
            result_valid_reg <= qq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < NUM_PARTS; p++)
            begin
                quot_reg[p]  <= quot_next[p];
                low_a_reg[p] <= sums[p][RES_W-1:0];
                qq_reg[p]    <= qq_full[p][RES_W-1:0];
                low_b_reg[p] <= low_a_reg[p];
            end
            result_reg <= result_next;
        end
    end

    assign valid_out = result_valid_reg;
    assign result    = result_reg;

endmodule

>>> hw/rtl/mac_share_modular_alu.sv
// Modular ALU over authenticated shares (value, MAC share, public offset), mod 8380417.
// Requests enter on req_valid/req_stall with req_type, three operand shares and two
// public constants; each request yields one result share on res_valid/res_stall.
// A request is taken at a clock edge where req_valid is high and req_stall is low.
// Operations: add, subtract, add constant, multiply by constant, Beaver finish.
// One request enters every cycle while no valid result is stalled: the six-stage
// pipeline (operand reduction, multiply, sum, Barrett quotient, quotient times
// modulus, final correction) holds one request per stage.
// When the receiver stalls a valid result, the whole pipeline holds and req_stall
// rises in the same cycle; nothing is dropped or repeated.
// The party_index register (APB byte address 0) holds the party; only party 1 adds
// public constants into its value. Write it only while no request is in flight.
// Reset clears party_index and every pipeline valid bit, so req_stall is low and the
// block accepts requests as soon as reset is released.
module mac_share_modular_alu
    import msma_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready,

    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [2:0]                req_type,
    input  logic [ELEM_W-1:0]         first_value,
    input  logic [ELEM_W-1:0]         first_mac,
    input  logic [ELEM_W-1:0]         first_offset,
    input  logic [ELEM_W-1:0]         second_value,
    input  logic [ELEM_W-1:0]         second_mac,
    input  logic [ELEM_W-1:0]         second_offset,
    input  logic [ELEM_W-1:0]         third_value,
    input  logic [ELEM_W-1:0]         third_mac,
    input  logic [ELEM_W-1:0]         third_offset,
    input  logic signed [CONST_W-1:0] const_one,
    input  logic [ELEM_W-1:0]         const_two,

    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [ELEM_W-1:0]         result_value,
    output logic [ELEM_W-1:0]         result_mac,
    output logic [ELEM_W-1:0]         result_offset
);

`include "mac_share_modular_alu_macros.svh"

    logic [PARTY_W-1:0] party_index_reg;
    logic               reg_hit;
    logic               en;
    share_t             first_share;
    share_t             second_share;
    share_t             third_share;
    logic               prep_valid;
    share_terms_t       terms;
    logic               mac_valid;
    share_sum_t         sums;
    share_t             result;

    assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_PARTY_INDEX);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? CFG_DATA_W'(party_index_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            party_index_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            party_index_reg <= pwdata[PARTY_W-1:0];
        end
    end

    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    always_comb
    begin
        first_share[PART_VALUE]   = first_value;
        first_share[PART_MAC]     = first_mac;
        first_share[PART_OFFSET]  = first_offset;
        second_share[PART_VALUE]  = second_value;
        second_share[PART_MAC]    = second_mac;
        second_share[PART_OFFSET] = second_offset;
        third_share[PART_VALUE]   = third_value;
        third_share[PART_MAC]     = third_mac;
        third_share[PART_OFFSET]  = third_offset;
    end

    msma_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (req_valid),
        .req_type    (req_type),
        .first       (first_share),
        .second      (second_share),
        .third       (third_share),
        .const_one   (const_one),
        .const_two   (const_two),
        .party_index (party_index_reg),
        .valid_out   (prep_valid),
        .terms       (terms)
    );

    msma_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (prep_valid),
        .terms     (terms),
        .valid_out (mac_valid),
        .sums      (sums)
    );

    msma_red u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mac_valid),
        .sums      (sums),
        .valid_out (res_valid),
        .result    (result)
    );

    assign result_value  = result[PART_VALUE];
    assign result_mac    = result[PART_MAC];
    assign result_offset = result[PART_OFFSET];

    // Every delivered part is fully reduced.
    `MSMA_ASSERT_SAME(a_result_reduced, res_valid,
        (result_value < MODULUS) && (result_mac < MODULUS) && (result_offset < MODULUS))

    // An accepted request comes out on res_valid when no stall comes between.
    `MSMA_ASSERT_SAME(a_latency_six,
        $past(rst_n, 6) && $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3) &&
        $past(rst_n, 2) && $past(rst_n, 1) && $past(req_valid, 6) &&
        !$past(req_stall, 6) && !$past(req_stall, 5) && !$past(req_stall, 4) &&
        !$past(req_stall, 3) && !$past(req_stall, 2) && !$past(req_stall, 1),
        res_valid)

    // A result held by the receiver stays valid and keeps its value and offset parts.
    `MSMA_ASSERT_NEXT(a_hold_on_stall, res_valid && res_stall,
        res_valid && $stable(result_value) && $stable(result_offset))

endmodule

>>> tb/mac_share_modular_alu_tb.sv
`timescale 1ns / 100ps

module mac_share_modular_alu_tb;
    import msma_pkg::*;

    localparam int PIPE_DEPTH = 6;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam longint Q = longint'(MODULUS_L);
    localparam elem_t ELEM_MAX = '1;
    localparam elem_t Q_MINUS_ONE = MODULUS - ONE;
    localparam logic signed [CONST_W-1:0] CONST_MIN = {1'b1, {(CONST_W-1){1'b0}}};
    localparam logic signed [CONST_W-1:0] CONST_MAX = {1'b0, {(CONST_W-1){1'b1}}};

    typedef struct {
        logic [2:0]                kind;
        share_t                    first;
        share_t                    second;
        share_t                    third;
        logic signed [CONST_W-1:0] eps;
        elem_t                     delta;
        int                        gap;
    } share_req_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]     paddr = '0;
    logic [CFG_DATA_W-1:0]     pwdata = '0;
    logic [CFG_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [2:0]                req_type = '0;
    logic [ELEM_W-1:0]         first_value = '0;
    logic [ELEM_W-1:0]         first_mac = '0;
    logic [ELEM_W-1:0]         first_offset = '0;
    logic [ELEM_W-1:0]         second_value = '0;
    logic [ELEM_W-1:0]         second_mac = '0;
    logic [ELEM_W-1:0]         second_offset = '0;
    logic [ELEM_W-1:0]         third_value = '0;
    logic [ELEM_W-1:0]         third_mac = '0;
    logic [ELEM_W-1:0]         third_offset = '0;
    logic signed [CONST_W-1:0] const_one = '0;
    logic [ELEM_W-1:0]         const_two = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    logic [ELEM_W-1:0]         result_value;
    logic [ELEM_W-1:0]         result_mac;
    logic [ELEM_W-1:0]         result_offset;

    share_req_t    pending_reqs[$];
    share_t        expected_shares[$];
    share_req_t    active_req;
    logic [PARTY_W-1:0] party_shadow = '0;
    int            idle_count = 0;
    int            rx_wait = 0;
    int            rx_idle_max = 16;
    int            long_hold_left = 0;
    bit            long_hold_arm = 1'b0;
    int            error_count = 0;
    int            cycle_count = 0;
    share_t        got_share;
    share_t        want_share;
    string         part_names[NUM_PARTS] = '{"result_value", "result_mac", "result_offset"};

    mac_share_modular_alu dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .first_value   (first_value),
        .first_mac     (first_mac),
        .first_offset  (first_offset),
        .second_value  (second_value),
        .second_mac    (second_mac),
        .second_offset (second_offset),
        .third_value   (third_value),
        .third_mac     (third_mac),
        .third_offset  (third_offset),
        .const_one     (const_one),
        .const_two     (const_two),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .result_value  (result_value),
        .result_mac    (result_mac),
        .result_offset (result_offset)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint mod_q(input longint x);
        longint r;
        r = x % Q;
        if (r < 0)
            r += Q;
        return r;
    endfunction

    // A public constant lands in the value only on the active party, and always
    // comes off the offset.
    function automatic share_t predict_share(input share_req_t r,
                                             input logic [PARTY_W-1:0] party);
        longint f[NUM_PARTS];
        longint s[NUM_PARTS];
        longint t[NUM_PARTS];
        longint acc[NUM_PARTS];
        longint eps;
        longint delta;
        longint k;
        share_t res;
        eps = mod_q(longint'(r.eps));
        delta = mod_q(longint'(r.delta));
        k = 0;
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            f[p] = mod_q(longint'(r.first[p]));
            s[p] = mod_q(longint'(r.second[p]));
            t[p] = mod_q(longint'(r.third[p]));
            acc[p] = 0;
        end
        case (r.kind)
            OP_ADD:
                for (int p = 0; p < NUM_PARTS; p++)
                    acc[p] = mod_q(f[p] + s[p]);
            OP_SUB:
                for (int p = 0; p < NUM_PARTS; p++)
                    acc[p] = mod_q(f[p] - s[p]);
            OP_ADD_CONST:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                    acc[p] = f[p];
                k = eps;
            end
            OP_MUL_CONST:
                for (int p = 0; p < NUM_PARTS; p++)
                    acc[p] = mod_q(f[p] * eps);
            OP_BEAVER:
            begin
                for (int p = 0; p < NUM_PARTS; p++)
                    acc[p] = mod_q(mod_q(f[p] * delta) + mod_q(s[p] * eps) + t[p]);
                k = mod_q(eps * delta);
            end
            default:
            begin
            end
        endcase
        if (r.kind == OP_ADD_CONST || r.kind == OP_BEAVER)
        begin
            if (party == ACTIVE_PARTY)
                acc[PART_VALUE] = mod_q(acc[PART_VALUE] + k);
            acc[PART_OFFSET] = mod_q(acc[PART_OFFSET] - k);
        end
        for (int p = 0; p < NUM_PARTS; p++)
            res[p] = elem_t'(acc[p]);
        return res;
    endfunction

    function automatic elem_t rand_elem();
        elem_t e;
        case ($urandom_range(0, 9))
            0: e = '0;
            1: e = Q_MINUS_ONE;
            2: e = elem_t'($urandom_range(int'(MODULUS_L), int'(ELEM_MAX)));
            3: e = ELEM_MAX;
            default: e = elem_t'($urandom_range(0, int'(ELEM_MAX)));
        endcase
        return e;
    endfunction

    function automatic logic signed [CONST_W-1:0] rand_const();
        logic signed [CONST_W-1:0] c;
        case ($urandom_range(0, 7))
            0: c = CONST_MIN;
            1: c = CONST_MAX;
            2: c = -1;
            3: c = CONST_W'(-(Q - 1));
            4: c = CONST_W'(Q - 1);
            default: c = CONST_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic share_t rand_share();
        share_t s;
        for (int p = 0; p < NUM_PARTS; p++)
            s[p] = rand_elem();
        return s;
    endfunction

    function automatic share_req_t make_req(input logic [2:0] kind, input share_t f,
                                            input share_t s, input share_t t,
                                            input logic signed [CONST_W-1:0] eps,
                                            input elem_t delta);
        share_req_t r;
        r.kind = kind;
        r.first = f;
        r.second = s;
        r.third = t;
        r.eps = eps;
        r.delta = delta;
        r.gap = 0;
        return r;
    endfunction

    task automatic push_directed();
        @(negedge clk);
        pending_reqs.push_back(make_req(OP_ADD, {3{Q_MINUS_ONE}}, {3{Q_MINUS_ONE}}, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_ADD, {3{ELEM_MAX}}, {3{ELEM_MAX}}, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_ADD, '0, '0, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_SUB, '0, {3{Q_MINUS_ONE}}, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_SUB, {3{Q_MINUS_ONE}}, '0, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_SUB, {3{ELEM_MAX}}, {3{MODULUS}}, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_ADD_CONST, {3{Q_MINUS_ONE}}, '0, '0,
                                        CONST_MIN, '0));
        pending_reqs.push_back(make_req(OP_ADD_CONST, '0, '0, '0, CONST_MAX, '0));
        pending_reqs.push_back(make_req(OP_ADD_CONST, {3{ELEM_MAX}}, '0, '0, -1, '0));
        pending_reqs.push_back(make_req(OP_ADD_CONST, rand_share(), '0, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_MUL_CONST, {3{Q_MINUS_ONE}}, '0, '0,
                                        CONST_MIN, '0));
        pending_reqs.push_back(make_req(OP_MUL_CONST, {3{Q_MINUS_ONE}}, '0, '0, -1, '0));
        pending_reqs.push_back(make_req(OP_MUL_CONST, {3{ELEM_MAX}}, '0, '0, CONST_MAX, '0));
        pending_reqs.push_back(make_req(OP_MUL_CONST, rand_share(), '0, '0, 0, '0));
        pending_reqs.push_back(make_req(OP_BEAVER, {3{Q_MINUS_ONE}}, {3{Q_MINUS_ONE}},
                                        {3{Q_MINUS_ONE}}, CONST_MIN, ELEM_MAX));
        pending_reqs.push_back(make_req(OP_BEAVER, {3{ELEM_MAX}}, {3{ELEM_MAX}},
                                        {3{ELEM_MAX}}, -1, Q_MINUS_ONE));
        pending_reqs.push_back(make_req(OP_BEAVER, '0, '0, '0, CONST_MAX, ELEM_MAX));
        pending_reqs.push_back(make_req(OP_BEAVER, rand_share(), rand_share(), rand_share(),
                                        rand_const(), rand_elem()));
        for (int k = OP_BEAVER + 1; k < 8; k++)
            pending_reqs.push_back(make_req(3'(k), rand_share(), rand_share(), rand_share(),
                                            rand_const(), rand_elem()));
    endtask

    // Every third stretch of fifty requests goes out back to back.
    task automatic push_random(input int count);
        share_req_t r;
        int sel;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 15);
            r = make_req((sel < 15) ? 3'(sel % 5) : 3'($urandom_range(OP_BEAVER + 1, 7)),
                         rand_share(), rand_share(), rand_share(), rand_const(), rand_elem());
            r.gap = ((i / 50) % 3 == 0) ? 0 : $urandom_range(0, 16);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_shares.size() != 0);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(4 * REG_PARTY_INDEX);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        party_shadow = value[PARTY_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            idle_count = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_shares.push_back(predict_share(active_req, party_shadow));
            if (!(req_valid && req_stall))
            begin
                if (pending_reqs.size() != 0 && idle_count >= pending_reqs[0].gap)
                begin
                    active_req = pending_reqs.pop_front();
                    idle_count = 0;
                    req_valid <= 1'b1;
                    req_type <= active_req.kind;
                    first_value <= active_req.first[PART_VALUE];
                    first_mac <= active_req.first[PART_MAC];
                    first_offset <= active_req.first[PART_OFFSET];
                    second_value <= active_req.second[PART_VALUE];
                    second_mac <= active_req.second[PART_MAC];
                    second_offset <= active_req.second[PART_OFFSET];
                    third_value <= active_req.third[PART_VALUE];
                    third_mac <= active_req.third[PART_MAC];
                    third_offset <= active_req.third[PART_OFFSET];
                    const_one <= active_req.eps;
                    const_two <= active_req.delta;
                end
                else
                begin
                    if (pending_reqs.size() != 0)
                        idle_count++;
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_hold_left <= 0;
        else if (long_hold_arm)
            long_hold_left <= LONG_HOLD;
        else if (long_hold_left > 0)
            long_hold_left <= long_hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got_share = {result_offset, result_mac, result_value};
                if (expected_shares.size() == 0)
                begin
                    $error("result_share arrived with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want_share = expected_shares.pop_front();
                    for (int p = 0; p < NUM_PARTS; p++)
                        if (got_share[p] !== want_share[p])
                        begin
                            $error("%s mismatch: expected %0d, actual %0d",
                                   part_names[p], want_share[p], got_share[p]);
                            error_count++;
                        end
                end
                rx_wait = $urandom_range(0, rx_idle_max);
            end
            else if (rx_wait > 0)
                rx_wait--;
            res_stall <= (long_hold_left != 0) || (rx_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("mac_share_modular_alu_tb failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_directed();
        drain();

        cfg_write(32'd1);
        rx_idle_max = 4;
        push_directed();
        push_random(300);
        drain();

        // The receiver holds off while the sender keeps pushing, so the pipeline
        // fills and backs up into the request side.
        cfg_write(32'd255);
        rx_idle_max = 16;
        push_random(300);
        long_hold_arm = 1'b1;
        @(negedge clk);
        long_hold_arm = 1'b0;
        drain();

        cfg_write(32'd0);
        rx_idle_max = 0;
        push_random(350);
        drain();

        cfg_write(32'hABCD_0001);
        rx_idle_max = 16;
        push_random(350);
        drain();

        cfg_write(CFG_DATA_W'($urandom_range(2, 254)));
        rx_idle_max = 8;
        push_random(300);
        drain();

        cfg_write(32'd1);
        rx_idle_max = 16;
        push_random(400);
        drain();

        if (error_count == 0)
            $display("mac_share_modular_alu_tb passed");
        else
            $display("mac_share_modular_alu_tb failed");
        $finish;
    end

endmodule
